FILE: src/dsld_pkg.sv
// ----------------------------------------------------------------------------
// dsld_pkg
// Item types, field constants and latency helpers for the deflection block.
// ----------------------------------------------------------------------------
package dsld_pkg;

  localparam int FIELD_W = 16;
  localparam int ROT_STAGES = 5;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
    logic signed [FIELD_W-1:0] mean_off_x;
    logic signed [FIELD_W-1:0] mean_off_y;
    logic signed [FIELD_W-1:0] final_off_x;
    logic signed [FIELD_W-1:0] final_off_y;
  } dsld_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] mean_x;
    logic signed [FIELD_W-1:0] mean_y;
    logic signed [FIELD_W-1:0] mean_z;
    logic signed [FIELD_W-1:0] final_x;
    logic signed [FIELD_W-1:0] final_y;
    logic signed [FIELD_W-1:0] final_z;
  } dsld_result_t;

  // radicand width shared by all three root pipelines (even)
  function automatic int rad_width(input int frac);
    return (2 * frac + 2 > 32) ? 2 * frac + 2 : 32;
  endfunction

  // cycles from accepted item to result strobe
  function automatic int latency(input int frac);
    return 2 + rad_width(frac) / 2 + (frac + 1) + ROT_STAGES;
  endfunction

endpackage

FILE: src/dsld_delay.sv
// ----------------------------------------------------------------------------
// dsld_delay
// Fixed-depth shift line that keeps item data aligned with the arithmetic.
// ----------------------------------------------------------------------------
module dsld_delay #(
  parameter int W = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

FILE: src/dsld_isqrt.sv
// ----------------------------------------------------------------------------
// dsld_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module dsld_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic [RW-1:0]   rad,
  output logic [RW/2-1:0] root
);

  localparam int SQW = RW / 2;

  logic [RW-1:0] v_q [SQW];
  logic [RW-1:0] r_q [SQW];
  logic [RW-1:0] v_in [SQW];
  logic [RW-1:0] r_in [SQW];

  assign v_in[0] = rad;
  assign r_in[0] = '0;

  for (genvar i = 0; i < SQW; i++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * i);
    logic [RW-1:0] trial;
    logic [RW-1:0] v_next;
    logic [RW-1:0] r_next;

    if (i > 0) begin : g_link
      assign v_in[i] = v_q[i-1];
      assign r_in[i] = r_q[i-1];
    end

    always_comb begin
      trial = r_in[i] + BIT;
      if (v_in[i] >= trial) begin
        v_next = v_in[i] - trial;
        r_next = (r_in[i] >> 1) + BIT;
      end else begin
        v_next = v_in[i];
        r_next = r_in[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      v_q[i] <= v_next;
      r_q[i] <= r_next;
    end
  end

  assign root = r_q[SQW-1][SQW-1:0];

endmodule

FILE: src/dsld_div.sv
// ----------------------------------------------------------------------------
// dsld_div
// Pipelined restoring divider for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dsld_div #(
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic [15:0]   num,
  input  logic [15:0]   den,
  output logic [QW-1:0] quo
);

  logic [15:0]   r_q [QW];
  logic [15:0]   d_q [QW];
  logic [QW-1:0] q_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [16:0]   r_in;
    logic [15:0]   d_in;
    logic [QW-1:0] q_in;
    logic          take;

    if (i == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = {r_q[i-1], 1'b0};
      assign d_in = d_q[i-1];
      assign q_in = q_q[i-1];
    end

    assign take = (r_in >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      r_q[i] <= take ? 16'(r_in - {1'b0, d_in}) : r_in[15:0];
      d_q[i] <= d_in;
      q_q[i] <= (q_in << 1) | QW'(take);
    end
  end

  assign quo = q_q[QW-1];

endmodule

FILE: src/dsld_rotate.sv
// ----------------------------------------------------------------------------
// dsld_rotate
// Tangent axes and the weighted sums of both rotated vectors, saturated.
// ----------------------------------------------------------------------------
module dsld_rotate #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  dsld_pkg::dsld_item_t        item,
  input  logic [15:0]                 sinz,
  input  logic signed [FRAC_BITS+1:0] cosa,
  input  logic signed [FRAC_BITS+1:0] sina,
  input  logic [FRAC_BITS:0]          mw,
  input  logic [FRAC_BITS:0]          fw,
  output dsld_pkg::dsld_result_t      result
);

  localparam int CW = FRAC_BITS + 2;
  localparam int PZW = FRAC_BITS + 18;
  localparam int SW = ((FRAC_BITS + 18 > 33) ? FRAC_BITS + 18 : 33) + 2;
  localparam logic signed [PZW-1:0] HALF_Z = PZW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAX_S = SW'(32767);
  localparam logic signed [SW-1:0] MIN_S = -SW'(32768);

  function automatic logic signed [15:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = (s + HALF_S) >>> FRAC_BITS;
    if (v > MAX_S) begin
      return 16'sh7fff;
    end else if (v < MIN_S) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // stage 1: cos zenith times cos / sin azimuth
  dsld_pkg::dsld_item_t        it1;
  logic [15:0]                 sz1;
  logic signed [CW-1:0]        ca1, sa1;
  logic [FRAC_BITS:0]          mw1, fw1;
  logic signed [PZW-1:0]       pzx1, pzy1;

  always_ff @(posedge clk) begin
    it1  <= item;
    sz1  <= sinz;
    ca1  <= cosa;
    sa1  <= sina;
    mw1  <= mw;
    fw1  <= fw;
    pzx1 <= $signed(item.dir_z) * cosa;
    pzy1 <= $signed(item.dir_z) * sina;
  end

  // stage 2: zenith and azimuth axes
  dsld_pkg::dsld_item_t        it2;
  logic [FRAC_BITS:0]          mw2, fw2;
  logic signed [16:0]          zx2, zy2, zz2;
  logic signed [CW-1:0]        ax2, ay2;
  logic signed [PZW-1:0]       tzx, tzy;

  assign tzx = (pzx1 + HALF_Z) >>> FRAC_BITS;
  assign tzy = (pzy1 + HALF_Z) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    it2 <= it1;
    mw2 <= mw1;
    fw2 <= fw1;
    zx2 <= tzx[16:0];
    zy2 <= tzy[16:0];
    zz2 <= -$signed({1'b0, sz1});
    ax2 <= -sa1;
    ay2 <= ca1;
  end

  // stage 3: products
  logic signed [CW-1:0] mws, fws;
  logic signed [SW-1:0] p_mwx, p_mwy, p_mwz, p_mzx, p_mzy, p_mzz, p_max, p_may;
  logic signed [SW-1:0] p_fwx, p_fwy, p_fwz, p_fzx, p_fzy, p_fzz, p_fax, p_fay;

  assign mws = $signed({1'b0, mw2});
  assign fws = $signed({1'b0, fw2});

  always_ff @(posedge clk) begin
    p_mwx <= mws * $signed(it2.dir_x);
    p_mwy <= mws * $signed(it2.dir_y);
    p_mwz <= mws * $signed(it2.dir_z);
    p_mzx <= $signed(it2.mean_off_x) * zx2;
    p_mzy <= $signed(it2.mean_off_x) * zy2;
    p_mzz <= $signed(it2.mean_off_x) * zz2;
    p_max <= $signed(it2.mean_off_y) * ax2;
    p_may <= $signed(it2.mean_off_y) * ay2;
    p_fwx <= fws * $signed(it2.dir_x);
    p_fwy <= fws * $signed(it2.dir_y);
    p_fwz <= fws * $signed(it2.dir_z);
    p_fzx <= $signed(it2.final_off_x) * zx2;
    p_fzy <= $signed(it2.final_off_x) * zy2;
    p_fzz <= $signed(it2.final_off_x) * zz2;
    p_fax <= $signed(it2.final_off_y) * ax2;
    p_fay <= $signed(it2.final_off_y) * ay2;
  end

  // stage 4: sums
  logic signed [SW-1:0] s_mx, s_my, s_mz, s_fx, s_fy, s_fz;

  always_ff @(posedge clk) begin
    s_mx <= p_mwx + p_mzx + p_max;
    s_my <= p_mwy + p_mzy + p_may;
    s_mz <= p_mwz + p_mzz;
    s_fx <= p_fwx + p_fzx + p_fax;
    s_fy <= p_fwy + p_fzy + p_fay;
    s_fz <= p_fwz + p_fzz;
  end

  // stage 5: round half up and saturate
  always_ff @(posedge clk) begin
    result.mean_x  <= round_sat(s_mx);
    result.mean_y  <= round_sat(s_my);
    result.mean_z  <= round_sat(s_mz);
    result.final_x <= round_sat(s_fx);
    result.final_y <= round_sat(s_fy);
    result.final_z <= round_sat(s_fz);
  end

endmodule

FILE: src/deflect_direction_local_frame.sv
// ----------------------------------------------------------------------------
// deflect_direction_local_frame
// Rotates a direction by a mean and a final transverse deflection pair.
// ----------------------------------------------------------------------------
// data path: squares, radicands, the root pipelines (one bit a stage), the azimuth
//   dividers and the rotate stages
// throughput: one item per cycle, busy is always low
// results are strobed on done for one cycle; the receiver cannot stall
// reset clears only the valid pipeline, data stages are not reset
module deflect_direction_local_frame #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  dsld_pkg::dsld_item_t   item,
  output logic                   done,
  output dsld_pkg::dsld_result_t result
);

  localparam int RW = dsld_pkg::rad_width(FRAC_BITS);
  localparam int SQW = RW / 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = FRAC_BITS + 2;
  localparam int LAT = dsld_pkg::latency(FRAC_BITS);
  localparam int IW = $bits(dsld_pkg::dsld_item_t);
  localparam int DFW = RW + 2;
  localparam int W2 = IW + 16 + 2 * (FRAC_BITS + 1);
  localparam logic signed [DFW-1:0] ONE2 = DFW'(1) << (2 * FRAC_BITS);
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  // pipeline never stalls, so an item is taken every cycle
  assign busy = 1'b0;

  // valid bits walk alongside the data
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

  // stage 1: squares of the direction x and y and of both deflection pairs
  dsld_pkg::dsld_item_t it1;
  logic signed [31:0]   xx1, yy1, maa1, mbb1, faa1, fbb1;

  always_ff @(posedge clk) begin
    it1  <= item;
    xx1  <= item.dir_x * item.dir_x;
    yy1  <= item.dir_y * item.dir_y;
    maa1 <= item.mean_off_x * item.mean_off_x;
    mbb1 <= item.mean_off_y * item.mean_off_y;
    faa1 <= item.final_off_x * item.final_off_x;
    fbb1 <= item.final_off_y * item.final_off_y;
  end

  // stage 2: radicands, longitudinal ones clamped at zero
  dsld_pkg::dsld_item_t  it2;
  logic [31:0]           s2_2;
  logic [RW-1:0]         radm2, radf2;
  logic [31:0]           mab, fab;
  logic signed [DFW-1:0] dm, df;

  assign mab = 32'(maa1[30:0]) + 32'(mbb1[30:0]);
  assign fab = 32'(faa1[30:0]) + 32'(fbb1[30:0]);
  assign dm  = ONE2 - $signed(DFW'(mab));
  assign df  = ONE2 - $signed(DFW'(fab));

  always_ff @(posedge clk) begin
    it2   <= it1;
    s2_2  <= 32'(xx1[30:0]) + 32'(yy1[30:0]);
    radm2 <= dm[DFW-1] ? '0 : dm[RW-1:0];
    radf2 <= df[DFW-1] ? '0 : df[RW-1:0];
  end

  // square roots: sin zenith and both longitudinal weights
  logic [SQW-1:0] sq_s, sq_m, sq_f;
  logic [IW-1:0]  it3_bits;

  dsld_isqrt #(.RW(RW)) u_sqrt_s (.clk(clk), .rad(RW'(s2_2)), .root(sq_s));
  dsld_isqrt #(.RW(RW)) u_sqrt_m (.clk(clk), .rad(radm2),     .root(sq_m));
  dsld_isqrt #(.RW(RW)) u_sqrt_f (.clk(clk), .rad(radf2),     .root(sq_f));

  dsld_delay #(.W(IW), .DEPTH(SQW)) u_dly_sqrt (
    .clk(clk), .din(it2), .dout(it3_bits)
  );

  dsld_pkg::dsld_item_t it3;
  logic [15:0]          sinz3, absx3, absy3;
  logic [FRAC_BITS:0]   mw3, fw3;

  assign it3   = it3_bits;
  assign sinz3 = sq_s[15:0];
  assign mw3   = sq_m[FRAC_BITS:0];
  assign fw3   = sq_f[FRAC_BITS:0];
  // magnitudes, the most negative value maps to 0x8000 unsigned
  assign absx3 = it3.dir_x[15] ? 16'(~it3.dir_x + 16'sd1) : it3.dir_x;
  assign absy3 = it3.dir_y[15] ? 16'(~it3.dir_y + 16'sd1) : it3.dir_y;

  // azimuth cos / sin as |x| / sinz and |y| / sinz, sign fixed afterwards
  logic [QW-1:0] qx4, qy4;
  logic [W2-1:0] d4;

  dsld_div #(.QW(QW)) u_div_x (.clk(clk), .num(absx3), .den(sinz3), .quo(qx4));
  dsld_div #(.QW(QW)) u_div_y (.clk(clk), .num(absy3), .den(sinz3), .quo(qy4));

  dsld_delay #(.W(W2), .DEPTH(QW)) u_dly_div (
    .clk(clk), .din({it3_bits, sinz3, mw3, fw3}), .dout(d4)
  );

  dsld_pkg::dsld_item_t it4;
  logic [15:0]          sinz4;
  logic [FRAC_BITS:0]   mw4, fw4;
  logic signed [CW-1:0] qxs, qys, cosa4, sina4;

  assign {it4, sinz4, mw4, fw4} = d4;
  assign qxs = $signed({1'b0, qx4});
  assign qys = $signed({1'b0, qy4});

  // direction on the z axis: cos azimuth one, sin azimuth zero
  always_comb begin
    if (sinz4 == 16'd0) begin
      cosa4 = ONE_C;
      sina4 = '0;
    end else begin
      cosa4 = it4.dir_x[15] ? -qxs : qxs;
      sina4 = it4.dir_y[15] ? -qys : qys;
    end
  end

  // tangent axes, weighted sums, rounding and saturation
  dsld_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk(clk),
    .item(it4),
    .sinz(sinz4),
    .cosa(cosa4),
    .sina(sina4),
    .mw(mw4),
    .fw(fw4),
    .result(result)
  );

endmodule

FILE: src/dsld_checker.sv
// ----------------------------------------------------------------------------
// dsld_checker
// Port-level checks of latency, strobe pairing and zero-deflection results.
// ----------------------------------------------------------------------------
module dsld_checker #(
  parameter int FRAC_BITS = 14
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input dsld_pkg::dsld_item_t   item,
  input logic                   done,
  input dsld_pkg::dsld_result_t result
);

  localparam int LAT = dsld_pkg::latency(FRAC_BITS);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted item gave no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_mean_zero_pass: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.mean_off_x == 16'sd0 && item.mean_off_y == 16'sd0
    |-> ##LAT (result.mean_x == $past(item.dir_x, LAT) &&
               result.mean_y == $past(item.dir_y, LAT) &&
               result.mean_z == $past(item.dir_z, LAT)))
    else $error("zero mean deflection changed the direction");

  a_final_zero_pass: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.final_off_x == 16'sd0 && item.final_off_y == 16'sd0
    |-> ##LAT (result.final_x == $past(item.dir_x, LAT) &&
               result.final_y == $past(item.dir_y, LAT) &&
               result.final_z == $past(item.dir_z, LAT)))
    else $error("zero final deflection changed the direction");

endmodule

bind deflect_direction_local_frame dsld_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
